// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the decoder controller.
// Each macro samples on clk_i and is disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/amsd_pkg.sv
// ---------------------------------------------------------------------------
// amsd_pkg
// Types, constants and helpers of the attribute markup stream decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package amsd_pkg;

  // Sizing.
  localparam int SPAN_SLOTS = 10;
  localparam int COUNT_BITS = 16;
  localparam int SLOT_W     = (SPAN_SLOTS > 1) ? $clog2(SPAN_SLOTS) : 1;

  // Byte codes recognized by the parser.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SOH   = 8'h01;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_M     = 8'h4D;

  // Result kinds.
  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_MARKUP = 1'b1;

  // Parser modes.
  typedef enum logic [2:0] {
    MODE_TEXT  = 3'd0,
    MODE_COUNT = 3'd1,
    MODE_ATTR  = 3'd2,
    MODE_COLOR = 3'd3,
    MODE_EAT   = 3'd4
  } mode_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RES0,
    ST_RES1
  } ctrl_state_e;

  // Attribute set; the packed order matches the output word layout.
  typedef struct packed {
    logic       italic;
    logic       reverse;
    logic       underline;
    logic       bold;
    logic       has_color;
    logic [3:0] color;
  } attr_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] text_char;
    attr_t      attr;
    logic       last;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;
    logic sel;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] res_cnt;
    logic       two_q;
  } dp_status_t;

  // Decodes a hex digit; bit 4 flags a valid digit.
  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [7:0] t;
    begin
      t = 8'd0;
      if (ch inside {[CH_ZERO:CH_NINE]}) begin
        t = ch - CH_ZERO;
        hex_value = {1'b1, t[3:0]};
      end else if (ch inside {[CH_UA:CH_UF]}) begin
        t = ch - CH_UA + 8'd10;
        hex_value = {1'b1, t[3:0]};
      end else if (ch inside {[CH_LA:CH_LF]}) begin
        t = ch - CH_LA + 8'd10;
        hex_value = {1'b1, t[3:0]};
      end else begin
        hex_value = 5'd0;
      end
    end
  endfunction

endpackage

// File: rtl/amsd_ctrl.sv
// ---------------------------------------------------------------------------
// amsd_ctrl
// Controller: takes one byte, then hands out its results one word at a time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module amsd_ctrl
  import amsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.res_cnt != 2'd0) begin
          state_d = ST_RES0;
        end
      end
      ST_RES0: begin
        if (out_ready_i) begin
          state_d = status_i.two_q ? ST_RES1 : ST_IDLE;
        end
      end
      ST_RES1: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ST_RES0: begin
        out_valid_o = 1'b1;
      end
      ST_RES1: begin
        out_valid_o = 1'b1;
        cmd_o.sel   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The second word is only ever reached through the first.
  `ASSERT_IMPLIES(a_res1_after_res0, state_q == ST_RES1,
                  $past(state_q) == ST_RES0 || $past(state_q) == ST_RES1)
  // A byte without results leaves the block ready.
  `ASSERT_NEXT(a_no_result_idle, cmd_o.take && status_i.res_cnt == 2'd0,
               state_q == ST_IDLE)
  // A byte with results presents a word on the next cycle.
  `ASSERT_NEXT(a_result_shown, cmd_o.take && status_i.res_cnt != 2'd0,
               out_valid_o)

endmodule

// File: rtl/amsd_dp.sv
// ---------------------------------------------------------------------------
// amsd_dp
// Datapath: parser registers, span slots and the two result registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module amsd_dp
  import amsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] in_byte_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  output result_t    res_o
);

  localparam int PROD_W = COUNT_BITS + 4;
  localparam logic [PROD_W-1:0] COUNT_MAX = {4'd0, {COUNT_BITS{1'b1}}};

  mode_e                 mode_q, mode_d;
  logic [COUNT_BITS-1:0] rep_q, rep_d;
  attr_t                 pend_q, pend_d;
  logic [COUNT_BITS-1:0] rem_q [SPAN_SLOTS];
  logic [COUNT_BITS-1:0] rem_d [SPAN_SLOTS];
  attr_t                 sattr_q [SPAN_SLOTS];
  attr_t                 sattr_d [SPAN_SLOTS];
  result_t               res_q [2];
  result_t               res_d [2];
  logic [1:0]            cnt_d;
  logic                  two_q;

  // Effect of an attribute letter.
  attr_t letter_attr;
  mode_e letter_mode;
  always_comb begin
    letter_attr = pend_q;
    letter_mode = MODE_ATTR;
    case (in_byte_i)
      CH_C: begin
        letter_mode         = MODE_COLOR;
        letter_attr.has_color = 1'b1;
      end
      CH_U: letter_attr.underline = 1'b1;
      CH_B: letter_attr.bold      = 1'b1;
      CH_R: letter_attr.reverse   = 1'b1;
      CH_I: letter_attr.italic    = 1'b1;
      CH_H, CH_M: letter_mode = MODE_EAT;
      default: ;
    endcase
  end

  // Repeat count accumulate with saturation.
  logic [PROD_W-1:0] prod;
  logic [7:0]        digit;
  always_comb begin
    digit = in_byte_i - CH_ZERO;
    prod  = ({4'd0, rep_q} << 3) + ({4'd0, rep_q} << 1) + {{(PROD_W-4){1'b0}}, digit[3:0]};
  end

  // Span countdown, rebuild and first free slot.
  logic                  changed;
  attr_t                 rebuilt;
  logic                  free_found;
  logic [SLOT_W-1:0]     free_idx;
  logic [COUNT_BITS-1:0] close_cnt;
  always_comb begin
    changed    = 1'b0;
    rebuilt    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int n = 0; n < SPAN_SLOTS; n++) begin
      if (rem_q[n] == {{(COUNT_BITS-1){1'b0}}, 1'b1}) begin
        changed = 1'b1;
      end
      if (rem_q[n] > {{(COUNT_BITS-1){1'b0}}, 1'b1}) begin
        rebuilt.bold      = rebuilt.bold | sattr_q[n].bold;
        rebuilt.underline = rebuilt.underline | sattr_q[n].underline;
        rebuilt.reverse   = rebuilt.reverse | sattr_q[n].reverse;
        rebuilt.italic    = rebuilt.italic | sattr_q[n].italic;
        if (!rebuilt.has_color) begin
          rebuilt.has_color = sattr_q[n].has_color;
          rebuilt.color     = rebuilt.color | sattr_q[n].color;
        end
      end
      if (!free_found && rem_q[n] == '0) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(n);
      end
    end
    close_cnt = (rep_q == '0) ? {{(COUNT_BITS-1){1'b0}}, 1'b1} : rep_q;
  end

  // Per-byte update.
  logic [4:0] hexv;
  always_comb begin
    mode_d  = mode_q;
    rep_d   = rep_q;
    pend_d  = pend_q;
    rem_d   = rem_q;
    sattr_d = sattr_q;
    res_d   = res_q;
    cnt_d   = 2'd0;
    hexv    = hex_value(in_byte_i);
    case (mode_q)
      MODE_TEXT: begin
        if (in_byte_i == CH_SOH) begin
          mode_d = MODE_COUNT;
          rep_d  = '0;
          pend_d = '0;
        end else begin
          for (int n = 0; n < SPAN_SLOTS; n++) begin
            if (rem_q[n] != '0) begin
              rem_d[n] = rem_q[n] - {{(COUNT_BITS-1){1'b0}}, 1'b1};
            end
          end
          res_d[0] = '{kind: KIND_CHAR, text_char: in_byte_i, attr: pend_q, last: !changed};
          cnt_d    = 2'd1;
          if (changed) begin
            pend_d   = rebuilt;
            res_d[1] = '{kind: KIND_MARKUP, text_char: 8'd0, attr: rebuilt, last: 1'b1};
            cnt_d    = 2'd2;
          end
        end
      end
      MODE_EAT: begin
        if (in_byte_i == CH_NUL) begin
          mode_d = MODE_TEXT;
        end
      end
      MODE_COUNT, MODE_ATTR, MODE_COLOR: begin
        if (in_byte_i == CH_COLON) begin
          if (pend_q != '0) begin
            res_d[0] = '{kind: KIND_MARKUP, text_char: 8'd0, attr: pend_q, last: 1'b1};
            cnt_d    = 2'd1;
            if (free_found) begin
              rem_d[free_idx]   = close_cnt;
              sattr_d[free_idx] = pend_q;
            end
          end
          rep_d  = close_cnt;
          mode_d = MODE_TEXT;
        end else if (mode_q == MODE_COUNT) begin
          if (in_byte_i inside {[CH_ZERO:CH_NINE]}) begin
            rep_d = (prod > COUNT_MAX) ? {COUNT_BITS{1'b1}} : prod[COUNT_BITS-1:0];
          end else begin
            mode_d = letter_mode;
            pend_d = letter_attr;
          end
        end else if (mode_q == MODE_ATTR) begin
          mode_d = letter_mode;
          pend_d = letter_attr;
        end else begin
          if (hexv[4]) begin
            pend_d.color = pend_q.color | hexv[3:0];
          end
          mode_d = MODE_ATTR;
        end
      end
      default: mode_d = MODE_TEXT;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_TEXT;
      rep_q  <= '0;
      pend_q <= '0;
      two_q  <= 1'b0;
      for (int n = 0; n < SPAN_SLOTS; n++) begin
        rem_q[n] <= '0;
      end
    end else if (cmd_i.take) begin
      mode_q <= mode_d;
      rep_q  <= rep_d;
      pend_q <= pend_d;
      two_q  <= (cnt_d == 2'd2);
      rem_q  <= rem_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      sattr_q <= sattr_d;
      res_q   <= res_d;
    end
  end

  assign status_o.res_cnt = cnt_d;
  assign status_o.two_q   = two_q;
  assign res_o            = res_q[cmd_i.sel];

endmodule

// File: rtl/attribute_markup_stream_decoder_top.sv
// ---------------------------------------------------------------------------
// attribute_markup_stream_decoder_top
// Decodes an annotated byte stream into character and markup result words.
// ---------------------------------------------------------------------------
// The slave channel takes one byte of the annotated text per word. The master
// channel returns result words: tuser is the kind (0 character, 1 markup
// change), tdata holds the character and the attribute set, and tlast marks
// the final word caused by one input byte.
// A byte is taken only while the block is idle. A byte that causes no word
// (markup text, swallowed bytes) leaves it idle. A byte that causes words
// shows its first word on the cycle after it was taken; with the receiver
// ready, one word leaves per cycle. The controller serves the two result
// registers in turn before it takes the next byte. When the receiver stalls,
// the current word holds on the master channel and no new byte is taken until
// all words of the byte have left.
// Reset clears the parser, the repeat count, the pending attributes and all
// span slots at once; the block is ready for bytes as soon as reset is released.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module attribute_markup_stream_decoder_top
  import amsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [7:0] text_char, [11:8] color_index,
                                     // [12] has_color, [13] bold, [14] underline,
                                     // [15] reverse, [16] italic, zero above
  output logic        m_axis_tuser,  // [0] kind
  output logic        m_axis_tlast   // last
);

  dp_cmd_t    cmd;
  dp_status_t status;
  result_t    res;

  amsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  amsd_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_byte_i (s_axis_tdata),
    .cmd_i     (cmd),
    .status_o  (status),
    .res_o     (res)
  );

  // Pack the result word.
  assign m_axis_tdata = {7'd0, res.attr, res.text_char};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

// File: bench/amsd_result_checker.sv
// ---------------------------------------------------------------------------
// amsd_result_checker
// Watches both stream channels of the markup decoder, predicts every result
// word from the accepted input bytes and compares the words that leave.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module amsd_result_checker
  import amsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [23:0] out_data_i,
  input  logic        out_kind_i,
  input  logic        out_last_i,
  output int          errors_o,
  output int          words_due_o,
  output int          words_seen_o
);

  // Bit positions of the 13-bit attribute word.
  localparam int POS_COLOR = 8;
  localparam int POS_BOLD  = 9;
  localparam int POS_UNDER = 10;
  localparam int POS_REV   = 11;
  localparam int POS_ITAL  = 12;

  localparam logic [12:0] FLAG_MASK  = 13'h1E00;
  localparam logic [12:0] COLOR_MASK = 13'h01FF;
  localparam longint      COUNT_MAX  = (longint'(1) << COUNT_BITS) - 1;

  // Shadow copy of the decoder state.
  mode_e                 mode_q;
  logic [COUNT_BITS-1:0] count_q;
  logic [12:0]           pend_q;
  logic [COUNT_BITS-1:0] span_left [SPAN_SLOTS];
  logic [12:0]           span_set  [SPAN_SLOTS];

  // Words predicted but not yet seen on the master channel.
  result_t due_words[$];

  function automatic result_t make_word(input logic kind, input logic [7:0] ch,
                                        input logic [12:0] a, input logic last);
    result_t r;
    r.kind           = kind;
    r.text_char      = ch;
    r.attr.color     = a[3:0];
    r.attr.has_color = a[POS_COLOR];
    r.attr.bold      = a[POS_BOLD];
    r.attr.underline = a[POS_UNDER];
    r.attr.reverse   = a[POS_REV];
    r.attr.italic    = a[POS_ITAL];
    r.last           = last;
    return r;
  endfunction

  // Attribute letter inside a markup sequence; anything unknown is ignored.
  task automatic take_letter(input logic [7:0] b);
    case (b)
      CH_C: begin
        mode_q = MODE_COLOR;
        pend_q[POS_COLOR] = 1'b1;
      end
      CH_U: pend_q[POS_UNDER] = 1'b1;
      CH_B: pend_q[POS_BOLD]  = 1'b1;
      CH_R: pend_q[POS_REV]   = 1'b1;
      CH_I: pend_q[POS_ITAL]  = 1'b1;
      CH_H, CH_M: mode_q = MODE_EAT;
      default: ;
    endcase
  endtask

  // Advances the shadow state by one byte and queues the words it causes.
  task automatic decode_byte(input logic [7:0] b);
    int                    n;
    logic                  expired;
    logic                  placed;
    logic [12:0]           a;
    logic [COUNT_BITS-1:0] cnt;
    longint                v;
    logic [7:0]            digit;
    logic                  is_hex;
    case (mode_q)
      MODE_TEXT: begin
        if (b == CH_SOH) begin
          mode_q  = MODE_COUNT;
          count_q = '0;
          pend_q  = '0;
        end else begin
          // Count down every live span; an expiry forces a rebuild.
          expired = 1'b0;
          for (n = 0; n < SPAN_SLOTS; n++) begin
            if (span_left[n] != 0) begin
              span_left[n] = span_left[n] - 1'b1;
              if (span_left[n] == 0) expired = 1'b1;
            end
          end
          due_words.push_back(make_word(KIND_CHAR, b, pend_q, !expired));
          if (expired) begin
            a = '0;
            for (n = 0; n < SPAN_SLOTS; n++) begin
              if (span_left[n] != 0) begin
                a |= span_set[n] & FLAG_MASK;
                if (!a[POS_COLOR]) a |= span_set[n] & COLOR_MASK;
              end
            end
            pend_q = a;
            due_words.push_back(make_word(KIND_MARKUP, 8'd0, pend_q, 1'b1));
          end
        end
      end
      MODE_EAT: begin
        if (b == CH_NUL) mode_q = MODE_TEXT;
      end
      default: begin
        if (b == CH_COLON) begin
          // Close the sequence; a span takes the first free slot if any.
          cnt = (count_q != 0) ? count_q : COUNT_BITS'(1);
          if (pend_q != 0) begin
            due_words.push_back(make_word(KIND_MARKUP, 8'd0, pend_q, 1'b1));
            placed = 1'b0;
            for (n = 0; n < SPAN_SLOTS; n++) begin
              if (!placed && span_left[n] == 0) begin
                span_left[n] = cnt;
                span_set[n]  = pend_q;
                placed       = 1'b1;
              end
            end
          end
          count_q = cnt;
          mode_q  = MODE_TEXT;
        end else if (mode_q == MODE_COUNT) begin
          if (b inside {[CH_ZERO:CH_NINE]}) begin
            v       = longint'(count_q) * 10 + longint'(b - CH_ZERO);
            count_q = (v > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0] : v[COUNT_BITS-1:0];
          end else begin
            mode_q = MODE_ATTR;
            take_letter(b);
          end
        end else if (mode_q == MODE_ATTR) begin
          take_letter(b);
        end else begin
          // Color digit: hex values are ORed in, other bytes are consumed.
          is_hex = 1'b1;
          digit  = 8'd0;
          if (b inside {[CH_ZERO:CH_NINE]})  digit = b - CH_ZERO;
          else if (b inside {[CH_UA:CH_UF]}) digit = b - CH_UA + 8'd10;
          else if (b inside {[CH_LA:CH_LF]}) digit = b - CH_LA + 8'd10;
          else is_hex = 1'b0;
          if (is_hex) pend_q[3:0] = pend_q[3:0] | digit[3:0];
          mode_q = MODE_ATTR;
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_val, got_val);
      errors_o++;
    end
  endtask

  // Compare the leaving word first, then predict from the accepted byte.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t w;
    int      n;
    if (!rst_ni) begin
      mode_q  = MODE_TEXT;
      count_q = '0;
      pend_q  = '0;
      for (n = 0; n < SPAN_SLOTS; n++) begin
        span_left[n] = '0;
        span_set[n]  = '0;
      end
      due_words.delete();
      errors_o     = 0;
      words_seen_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        words_seen_o++;
        if (due_words.size() == 0) begin
          $error("Unexpected word: tdata %h tuser %b tlast %b",
                 out_data_i, out_kind_i, out_last_i);
          errors_o++;
        end else begin
          w = due_words.pop_front();
          check_field("kind", w.kind, out_kind_i);
          check_field("text_char", w.text_char, out_data_i[7:0]);
          check_field("color_index", w.attr.color, out_data_i[11:8]);
          check_field("has_color", w.attr.has_color, out_data_i[12]);
          check_field("bold", w.attr.bold, out_data_i[13]);
          check_field("underline", w.attr.underline, out_data_i[14]);
          check_field("reverse", w.attr.reverse, out_data_i[15]);
          check_field("italic", w.attr.italic, out_data_i[16]);
          check_field("padding", 0, out_data_i[23:17]);
          check_field("last", w.last, out_last_i);
        end
      end
      if (in_valid_i && in_ready_i) decode_byte(in_byte_i);
    end
    words_due_o = due_words.size();
  end

endmodule

// File: bench/attribute_markup_stream_decoder_top_test.sv
// ---------------------------------------------------------------------------
// attribute_markup_stream_decoder_top_test
// Drives annotated text into the markup decoder and gives the verdict.
// ---------------------------------------------------------------------------
// A short directed stream hits the corner cases of the parser, then random
// text runs, markup sequences, swallow runs, broken sequences and bursts that
// fill every span slot follow. Both channels idle at random; a separate
// checker predicts and compares every result word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module attribute_markup_stream_decoder_top_test;
  import amsd_pkg::*;

  localparam int     RANDOM_BYTES = 1900;
  localparam longint CYCLE_LIMIT  = 2_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  int     errors;
  int     words_due;
  int     words_seen;
  longint cycle_cnt;
  int     stall_left;
  logic   steady;
  int     bytes_sent;
  int     sequences_sent;
  int     swallows_sent;

  attribute_markup_stream_decoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  amsd_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_kind_i   (m_axis_tuser),
    .out_last_i   (m_axis_tlast),
    .errors_o     (errors),
    .words_due_o  (words_due),
    .words_seen_o (words_seen)
  );

  // 10 ns clock; it starts low so that no rising edge falls on time zero.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles", cycle_cnt);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Idle length: mostly short, now and then a long one.
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random stalls; no new stall starts during steady stretches.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 99) < 25) begin
      m_axis_tready <= 1'b0;
      stall_left    <= idle_len() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Offers one byte, after an optional gap, and waits until it is taken.
  // The valid stays high on return so that a back-to-back word needs no toggle.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (steady || $urandom_range(0, 99) < 65) ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Well-formed markup sequence: optional count, attribute letters, colon.
  // A negative count sends no digits.
  task automatic send_sequence(input int cnt, input int letters);
    string      digits;
    int         k;
    int         r;
    logic [7:0] b;
    sequences_sent++;
    send_byte(CH_SOH);
    if (cnt >= 0) begin
      digits = $sformatf("%0d", cnt);
      for (k = 0; k < digits.len(); k++) send_byte(digits[k]);
    end
    for (k = 0; k < letters; k++) begin
      r = $urandom_range(0, 11);
      if (r <= 2) begin
        send_byte(CH_C);
        r = $urandom_range(0, 24);
        if (r < 10)      b = CH_ZERO + 8'(r);
        else if (r < 16) b = CH_UA + 8'(r - 10);
        else if (r < 22) b = CH_LA + 8'(r - 16);
        else             b = 8'($urandom_range(CH_LF + 1, 8'hFF));
        send_byte(b);
      end else if (r <= 4) begin
        send_byte(CH_U);
      end else if (r <= 6) begin
        send_byte(CH_B);
      end else if (r <= 8) begin
        send_byte(CH_R);
      end else if (r <= 10) begin
        send_byte(CH_I);
      end else begin
        // Random byte; keep clear of the close and swallow codes.
        b = 8'($urandom_range(0, 255));
        if (b == CH_COLON || b == CH_H || b == CH_M) b = 8'h51;
        send_byte(b);
      end
    end
    send_byte(CH_COLON);
  endtask

  // Stops offering bytes until every predicted word has left.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (words_due != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] directed [];
    int         k;
    int         n;
    int         choice;
    int         cnt;
    logic [7:0] b;

    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = 8'd0;
    m_axis_tready  = 1'b0;
    cycle_cnt      = 0;
    stall_left     = 0;
    steady         = 1'b0;
    bytes_sent     = 0;
    sequences_sent = 0;
    swallows_sent  = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: byte extremes; a sequence with a zero count, a
    // non-hex color digit, two ORed color digits, unknown letters and all
    // flags; an expiring span; an empty sequence; a swallow with a colon
    // inside that keeps the gathered attributes.
    directed = {8'h41, 8'hFF,
                CH_SOH, CH_ZERO, CH_C, 8'h5A, CH_C, 8'h33, CH_C, 8'h63, 8'h78,
                CH_SOH, CH_U, CH_B, CH_R, CH_I, CH_COLON,
                CH_NUL,
                CH_SOH, CH_COLON,
                CH_SOH, CH_B, CH_H, CH_COLON, 8'h37, CH_NUL,
                8'h80};
    foreach (directed[k]) send_byte(directed[k]);
    drain_results();

    // Random part.
    n = bytes_sent;
    while (bytes_sent < n + RANDOM_BYTES) begin
      if (steady) steady = ($urandom_range(0, 99) >= 10);
      else        steady = ($urandom_range(0, 99) < 4);
      choice = $urandom_range(0, 99);
      if (choice < 50) begin
        // Plain text; a stray sequence opener is kept out of it.
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 99) < 80) b = 8'($urandom_range(8'h20, 8'h7E));
          else                            b = 8'($urandom_range(0, 255));
          if (b == CH_SOH) b = 8'h02;
          send_byte(b);
        end
      end else if (choice < 82) begin
        k = $urandom_range(0, 99);
        if (k < 30)      cnt = -1;
        else if (k < 40) cnt = 0;
        else if (k < 85) cnt = $urandom_range(1, 9);
        else             cnt = $urandom_range(10, 40);
        send_sequence(cnt, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4));
      end else if (choice < 89) begin
        // Swallow run, colons and openers included, ended by a NUL.
        swallows_sent++;
        send_byte(CH_SOH);
        if ($urandom_range(0, 1)) send_byte(CH_B);
        send_byte($urandom_range(0, 1) ? CH_H : CH_M);
        repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(1, 255)));
        send_byte(CH_NUL);
      end else if (choice < 95) begin
        // Broken sequence; the NUL and the colon bring the parser back.
        send_byte(CH_SOH);
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
        send_byte(CH_NUL);
        send_byte(CH_COLON);
      end else if (choice < 98) begin
        // Enough long spans to fill every slot and drop the rest.
        repeat (SPAN_SLOTS + 2) send_sequence($urandom_range(20, 60), 1);
      end else begin
        drain_results();
      end
    end

    // Count overflow: the span saturates and outlives the rest of the run.
    steady = 1'b0;
    send_sequence(999999, 2);
    repeat (6) send_byte(8'($urandom_range(8'h20, 8'h7E)));

    drain_results();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d bytes: %0d markup sequences, %0d swallow runs.",
             bytes_sent, sequences_sent, swallows_sent);
    $display("Checked %0d result words in %0d cycles.", words_seen, cycle_cnt);
    if (errors == 0 && words_due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/amsd_pkg.sv
rtl/amsd_ctrl.sv
rtl/amsd_dp.sv
rtl/attribute_markup_stream_decoder_top.sv
bench/amsd_result_checker.sv
bench/attribute_markup_stream_decoder_top_test.sv
